// ===== hdl/ssc_pkg.sv =====
// shared constants, types and helpers of the shake severity classifier
package ssc_pkg;

    // sample and baseline geometry
    localparam int BASELINE_SAMPLES = 100;
    localparam int AXES             = 6;
    localparam int SENSOR_AXES      = 3;
    localparam int SAMPLE_W         = 16;
    localparam int LEARN_W          = 7;
    localparam int SUM_W            = 24;
    localparam int DEV_W            = 16;
    localparam int SQ_W             = 2 * DEV_W;
    localparam int SUMSQ_W          = SQ_W + 2;
    localparam int LIMIT_W          = 16;
    localparam int AXIS_IDX_W       = 3;

    // divide by BASELINE_SAMPLES as multiply by a rounded-up reciprocal,
    // exact for any sum magnitude below 2^SUM_W and any count below 2^LEARN_W
    localparam int DIV_SHIFT = SUM_W + LEARN_W;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int QUO_W     = PROD_W - DIV_SHIFT;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(
        ((64'd1 << DIV_SHIFT) + 64'(BASELINE_SAMPLES) - 64'd1) / 64'(BASELINE_SAMPLES));

    // register file
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam logic [REG_IDX_W-1:0] REG_ACC_MILD      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACC_MODERATE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACC_SEVERE    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GYRO_MILD     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GYRO_MODERATE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GYRO_SEVERE   = 3'd5;

    localparam logic [LIMIT_W-1:0] RST_ACC_MILD      = 16'd500;
    localparam logic [LIMIT_W-1:0] RST_ACC_MODERATE  = 16'd2000;
    localparam logic [LIMIT_W-1:0] RST_ACC_SEVERE    = 16'd5000;
    localparam logic [LIMIT_W-1:0] RST_GYRO_MILD     = 16'd5000;
    localparam logic [LIMIT_W-1:0] RST_GYRO_MODERATE = 16'd20000;
    localparam logic [LIMIT_W-1:0] RST_GYRO_SEVERE   = 16'd50000;

    // command codes
    localparam logic [1:0] CMD_SAMPLE      = 2'd0;
    localparam logic [1:0] CMD_CLEAR_FLAG  = 2'd1;
    localparam logic [1:0] CMD_CLEAR_COUNT = 2'd2;

    // severity codes
    localparam logic [1:0] SEV_STABLE   = 2'd0;
    localparam logic [1:0] SEV_MILD     = 2'd1;
    localparam logic [1:0] SEV_MODERATE = 2'd2;
    localparam logic [1:0] SEV_SEVERE   = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [SQ_W-1:0]            t_square;
    typedef logic [LIMIT_W-1:0]         t_limit;

    // squared absolute deviation of one axis from its baseline
    function automatic t_square dev_square(input t_sample smp, input t_sample base);
        logic signed [DEV_W:0] d;
        logic signed [DEV_W:0] nd;
        logic [DEV_W-1:0]      m;
        d  = {smp[SAMPLE_W-1], smp} - {base[SAMPLE_W-1], base};
        nd = -d;
        m  = d[DEV_W] ? nd[DEV_W-1:0] : d[DEV_W-1:0];
        return SQ_W'(m) * SQ_W'(m);
    endfunction

endpackage

// ===== hdl/shake_severity_classifier_top.sv =====
// shake severity classifier: baseline learning, sum-of-squares deviation, severity grading
//
// Takes one word per clock while the result channel is not back-pressured, and returns
// one result word per input word, in order. Words pass through the input register,
// the squarer register and the result register; the sums of squares and the six limit
// compares sit in front of the result register. The rate also breaks after the sample
// that completes the baseline: stage a is held while one shared reciprocal multiplier
// turns the six baseline sums into averages, one axis per cycle.
// Write limits only while no word is in flight; a word accepted at or after the
// write edge is graded against the new limit.
module shake_severity_classifier_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  ssc_pkg::t_sample              i_accel_x,
    input  ssc_pkg::t_sample              i_accel_y,
    input  ssc_pkg::t_sample              i_accel_z,
    input  ssc_pkg::t_sample              i_rate_x,
    input  ssc_pkg::t_sample              i_rate_y,
    input  ssc_pkg::t_sample              i_rate_z,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_severity,
    output logic                          o_learning,
    output logic                          o_shake_flag,
    output logic [31:0]                   o_shake_total,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssc_pkg::PADDR_W-1:0]   paddr,
    input  logic [ssc_pkg::PDATA_W-1:0]   pwdata,
    output logic [ssc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import ssc_pkg::*;

    // limits and their squares
    t_limit                  r_lim [NUM_REGS];
    t_square                 r_lim_sq [NUM_REGS];
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    cfg_wr;

    // stage a: accepted word
    logic                    r_a_vld;
    logic [1:0]              r_a_cmd;
    t_sample                 r_a_smp [AXES];

    // stage b: squared deviations
    logic                    r_b_vld;
    logic [1:0]              r_b_cmd;
    logic                    r_b_learning;
    t_square                 r_b_sq [AXES];

    // result register
    logic                    r_o_vld;
    logic [1:0]              r_o_sev;
    logic                    r_o_learning;

    // learning and shake state
    t_sum                    r_sums [AXES];
    t_sum                    n_sums [AXES];
    t_sample                 r_base [AXES];
    logic [LEARN_W-1:0]      r_learn;
    logic [LEARN_W-1:0]      n_learn;
    logic                    r_base_ready;
    logic                    r_flag;
    logic                    n_flag;
    logic [31:0]             r_count;
    logic [31:0]             n_count;
    logic                    learn_done;

    // baseline divider
    logic                    r_div_busy;
    logic                    r_div_iss;
    logic [AXIS_IDX_W-1:0]   r_div_idx;
    logic                    r_p_vld;
    logic [AXIS_IDX_W-1:0]   r_p_idx;
    logic                    r_p_neg;
    logic [PROD_W-1:0]       r_prod;
    t_sum                    div_sum;
    logic [SUM_W-1:0]        div_abs;
    logic [QUO_W-1:0]        quo;
    logic [QUO_W-1:0]        quo_s;

    // handshake
    logic                    o_free;
    logic                    b_move;
    logic                    b_free;
    logic                    a_move;
    logic                    a_free;
    logic                    in_acc;

    // sums of squares and grading
    logic [SUMSQ_W-1:0]      acc_ss;
    logic [SUMSQ_W-1:0]      gyr_ss;
    logic [1:0]              sev;
    logic                    classify;

    // pipeline flow control
    assign o_free     = !r_o_vld || i_out_ready;
    assign b_move     = r_b_vld && o_free;
    assign b_free     = !r_b_vld || o_free;
    assign a_move     = r_a_vld && !r_div_busy && b_free;
    assign a_free     = !r_a_vld || a_move;
    assign in_acc     = i_in_valid && a_free;
    assign o_in_ready = a_free;

    assign o_out_valid   = r_o_vld;
    assign o_severity    = r_o_sev;
    assign o_learning    = r_o_learning;
    assign o_shake_flag  = r_flag;
    assign o_shake_total = r_count;

    // register port decode
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        prdata = '0;
        if (reg_idx < REG_IDX_W'(NUM_REGS)) begin
            prdata = PDATA_W'(r_lim[reg_idx]);
        end
    end

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim[REG_ACC_MILD]      <= RST_ACC_MILD;
            r_lim[REG_ACC_MODERATE]  <= RST_ACC_MODERATE;
            r_lim[REG_ACC_SEVERE]    <= RST_ACC_SEVERE;
            r_lim[REG_GYRO_MILD]     <= RST_GYRO_MILD;
            r_lim[REG_GYRO_MODERATE] <= RST_GYRO_MODERATE;
            r_lim[REG_GYRO_SEVERE]   <= RST_GYRO_SEVERE;
        end else if (cfg_wr && reg_idx < REG_IDX_W'(NUM_REGS)) begin
            r_lim[reg_idx] <= pwdata[LIMIT_W-1:0];
        end
    end

    // squared limits, refreshed every cycle
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_REGS; k++) begin
            r_lim_sq[k] <= SQ_W'(r_lim[k]) * SQ_W'(r_lim[k]);
        end
    end

    // learning update for the word leaving stage a
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            n_sums[k] = r_sums[k] + SUM_W'(r_a_smp[k]);
        end
        n_learn    = r_learn + LEARN_W'(1);
        learn_done = n_learn >= LEARN_W'(BASELINE_SAMPLES);
    end

    // stage a and learning state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_learn <= '0;
            for (int k = 0; k < AXES; k++) begin
                r_sums[k] <= '0;
            end
        end else begin
            r_a_vld <= in_acc || (r_a_vld && !a_move);
            if (a_move && r_a_cmd == CMD_SAMPLE && !r_base_ready) begin
                r_learn <= n_learn;
                for (int k = 0; k < AXES; k++) begin
                    r_sums[k] <= n_sums[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_cmd    <= i_command;
            r_a_smp[0] <= i_accel_x;
            r_a_smp[1] <= i_accel_y;
            r_a_smp[2] <= i_accel_z;
            r_a_smp[3] <= i_rate_x;
            r_a_smp[4] <= i_rate_y;
            r_a_smp[5] <= i_rate_z;
        end
    end

    // stage b: deviation squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= a_move || (r_b_vld && !b_move);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_cmd      <= r_a_cmd;
            r_b_learning <= !r_base_ready;
            for (int k = 0; k < AXES; k++) begin
                r_b_sq[k] <= dev_square(r_a_smp[k], r_base[k]);
            end
        end
    end

    // baseline divider: one axis issued per cycle into a registered product
    assign div_sum = r_sums[r_div_idx];
    assign div_abs = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
    assign quo     = r_prod[PROD_W-1:DIV_SHIFT];
    assign quo_s   = r_p_neg ? -quo : quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy   <= 1'b0;
            r_div_iss    <= 1'b0;
            r_div_idx    <= '0;
            r_p_vld      <= 1'b0;
            r_base_ready <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_base[k] <= '0;
            end
        end else begin
            if (a_move && r_a_cmd == CMD_SAMPLE && !r_base_ready && learn_done) begin
                r_div_busy <= 1'b1;
                r_div_iss  <= 1'b1;
                r_div_idx  <= '0;
            end else if (r_div_iss) begin
                r_div_idx <= r_div_idx + AXIS_IDX_W'(1);
                if (r_div_idx == AXIS_IDX_W'(AXES - 1)) begin
                    r_div_iss <= 1'b0;
                end
            end
            r_p_vld <= r_div_iss;
            // writeback of one average; the last axis opens the classifier
            if (r_p_vld) begin
                r_base[r_p_idx] <= quo_s[SAMPLE_W-1:0];
                if (r_p_idx == AXIS_IDX_W'(AXES - 1)) begin
                    r_div_busy   <= 1'b0;
                    r_base_ready <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_iss) begin
            r_p_idx <= r_div_idx;
            r_p_neg <= div_sum[SUM_W-1];
            r_prod  <= PROD_W'(div_abs) * PROD_W'(DIV_RECIP);
        end
    end

    // sums of squares and severity grading
    always_comb begin
        acc_ss = SUMSQ_W'(r_b_sq[0]) + SUMSQ_W'(r_b_sq[1]) + SUMSQ_W'(r_b_sq[2]);
        gyr_ss = SUMSQ_W'(r_b_sq[SENSOR_AXES]) + SUMSQ_W'(r_b_sq[SENSOR_AXES + 1])
               + SUMSQ_W'(r_b_sq[SENSOR_AXES + 2]);
        classify = r_b_cmd == CMD_SAMPLE && !r_b_learning;
        sev = SEV_STABLE;
        if (classify) begin
            priority if (acc_ss > SUMSQ_W'(r_lim_sq[REG_ACC_SEVERE]) ||
                         gyr_ss > SUMSQ_W'(r_lim_sq[REG_GYRO_SEVERE])) begin
                sev = SEV_SEVERE;
            end else if (acc_ss > SUMSQ_W'(r_lim_sq[REG_ACC_MODERATE]) ||
                         gyr_ss > SUMSQ_W'(r_lim_sq[REG_GYRO_MODERATE])) begin
                sev = SEV_MODERATE;
            end else if (acc_ss > SUMSQ_W'(r_lim_sq[REG_ACC_MILD]) ||
                         gyr_ss > SUMSQ_W'(r_lim_sq[REG_GYRO_MILD])) begin
                sev = SEV_MILD;
            end else begin
                sev = SEV_STABLE;
            end
        end
    end

    // shake flag and counter update
    always_comb begin
        n_flag  = r_flag;
        n_count = r_count;
        unique case (r_b_cmd)
            CMD_SAMPLE: begin
                if (classify) begin
                    n_flag = sev != SEV_STABLE;
                    if (sev != SEV_STABLE) begin
                        n_count = r_count + 32'd1;
                    end
                end
            end
            CMD_CLEAR_FLAG: begin
                n_flag = 1'b0;
            end
            CMD_CLEAR_COUNT: begin
                n_count = '0;
            end
            default: begin
                n_flag  = r_flag;
                n_count = r_count;
            end
        endcase
    end

    // result register and shake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_flag  <= 1'b0;
            r_count <= '0;
        end else begin
            r_o_vld <= b_move || (r_o_vld && !i_out_ready);
            if (b_move) begin
                r_flag  <= n_flag;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_o_sev      <= sev;
            r_o_learning <= r_b_learning;
        end
    end

endmodule
